// ===== src/pmbs_pkg.sv =====
// Package for the point map bilinear sampler.
// Widths, opcodes, register indexes, the map entry layout and the sequencer states.
// No dependencies.
`default_nettype none

package pmbs_pkg;

  // sizing of the map and of the positions
  localparam int unsigned MAX_WIDTH   = 128;
  localparam int unsigned MAX_HEIGHT  = 128;
  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  // fixed field widths
  localparam int unsigned IDX_W   = 14;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned POS_W   = 20;
  localparam int unsigned DIM_W   = 8;
  localparam int unsigned CELL_W  = POS_W - FRAC_BITS;

  // blend arithmetic
  localparam int unsigned WGT_W = 2 * FRAC_BITS + 1;
  localparam int unsigned ACC_W = COORD_W + 2 * FRAC_BITS + 2;

  // configuration port
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam logic [DIM_W-1:0] DIM_RESET = 8'd128;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // one map entry as held in the store
  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } entry_t;

  // query sequencer
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADDR = 4'b0010,
    S_RUN  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

endpackage

`default_nettype wire

// ===== src/point_map_bilinear_sampler.sv =====
// Top level of the point map bilinear sampler: point store, query sequencer, blend datapath.
// Depends on pmbs_pkg.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+-----------------------------
//  command  | opcode_i, point_*_i, query_col/row_i      | start && !busy
//  result   | result_x/y/z_o, result_valid_o            | done_o, one cycle, no stall
//  config   | psel, penable, pwrite, paddr, pwdata      | APB, pready tied high
//
// A load transaction leaves busy low. A query keeps busy high through an address
// state, four reads through the single read port of the point store, a drain of the
// multiply and accumulate, and a rounding state; done_o follows in the next cycle.
// A query whose cell is out of bounds goes from the address state to the rounding state.
// Reset clears control state and the size registers; the store is not cleared.
// The result side cannot stall, so results never wait.
`default_nettype none

module point_map_bilinear_sampler
  import pmbs_pkg::*;
(
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // command channel
  input  wire                        start,
  output logic                       busy,
  input  wire                        opcode_i,
  input  wire         [IDX_W-1:0]    point_index_i,
  input  wire  signed [COORD_W-1:0]  point_x_i,
  input  wire  signed [COORD_W-1:0]  point_y_i,
  input  wire  signed [COORD_W-1:0]  point_z_i,
  input  wire                        point_valid_i,
  input  wire  signed [POS_W-1:0]    query_col_i,
  input  wire  signed [POS_W-1:0]    query_row_i,
  // result channel
  output logic                       done_o,
  output logic signed [COORD_W-1:0]  result_x_o,
  output logic signed [COORD_W-1:0]  result_y_o,
  output logic signed [COORD_W-1:0]  result_z_o,
  output logic                       result_valid_o,
  // configuration port
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire         [PADDR_W-1:0]  paddr,
  input  wire         [PDATA_W-1:0]  pwdata,
  output logic        [PDATA_W-1:0]  prdata,
  output logic                       pready
);

  localparam logic [ACC_W-1:0] RND = ACC_W'(1) << (2 * FRAC_BITS - 1);
  localparam logic [FRAC_BITS:0] ONE_S = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  state_e state_q, state_d;

  logic [DIM_W-1:0] map_width_q, map_height_q;
  logic [DIM_W-1:0] w_eff, h_eff;

  logic signed [POS_W-1:0] col_q, row_q;
  logic [IDX_W-1:0]     base_q, base_d;
  logic [FRAC_BITS-1:0] fx_q, fy_q;
  logic                 inb_q, inb_d;
  logic [2:0]           ph_q, ph_d;
  logic [WGT_W-1:0]     wgt_q, wgt_d;
  logic                 all_vld_q, all_vld_d;

  logic signed [ACC_W-1:0] prod_q [3];
  logic signed [ACC_W-1:0] prod_d [3];
  logic signed [ACC_W-1:0] acc_q  [3];
  logic signed [ACC_W-1:0] acc_d  [3];
  logic signed [ACC_W-1:0] rnd    [3];

  logic                 done_q;
  logic [COORD_W-1:0]   res_q [3];
  logic                 res_vld_q;

  // point store
  entry_t           point_store_q [STORE_DEPTH];
  entry_t           rdata_q;
  logic             rd_en;
  logic [IDX_W-1:0] raddr;
  logic             wr_en;
  entry_t           wdata;

  logic accept;
  logic cfg_wr;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q  <= DIM_RESET;
      map_height_q <= DIM_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH) begin
        map_width_q <= pwdata[DIM_W-1:0];
      end else begin
        map_height_q <= pwdata[DIM_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_WIDTH) ? PDATA_W'(map_width_q) : PDATA_W'(map_height_q);

  // saturate the map size to the store
  assign w_eff = (map_width_q  > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : map_width_q;
  assign h_eff = (map_height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : map_height_q;

  // store write on load, read during a query
  assign wr_en = accept && (opcode_i == OP_LOAD) &&
                 ({1'b0, point_index_i} < (IDX_W + 1)'(STORE_DEPTH));
  assign wdata = '{valid: point_valid_i, z: point_z_i, y: point_y_i, x: point_x_i};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      point_store_q[point_index_i] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= point_store_q[raddr];
    end
  end

  // query capture
  always_ff @(posedge clk_i) begin
    if (accept && (opcode_i == OP_QUERY)) begin
      col_q <= query_col_i;
      row_q <= query_row_i;
    end
  end

  // address stage: bounds check, top-left index, fractions
  logic [CELL_W-1:0]        c0, r0;
  logic [CELL_W:0]          c_next, r_next;
  logic [CELL_W+DIM_W-1:0]  lin;

  always_comb begin
    c0     = col_q[POS_W-1:FRAC_BITS];
    r0     = row_q[POS_W-1:FRAC_BITS];
    c_next = {1'b0, c0} + (CELL_W + 1)'(1);
    r_next = {1'b0, r0} + (CELL_W + 1)'(1);
    inb_d  = !col_q[POS_W-1] && !row_q[POS_W-1] &&
             (c_next < (CELL_W + 1)'(w_eff)) && (r_next < (CELL_W + 1)'(h_eff));
    lin    = (CELL_W + DIM_W)'(r0) * (CELL_W + DIM_W)'(w_eff) + (CELL_W + DIM_W)'(c0);
    base_d = lin[IDX_W-1:0];
  end

  // read address and weight of neighbor ph[1:0]: bit 0 steps a column, bit 1 a row
  logic [FRAC_BITS:0]       a_w, b_w;
  logic [2*FRAC_BITS+1:0]   wgt_full;

  always_comb begin
    a_w      = ph_q[0] ? {1'b0, fx_q} : (ONE_S - {1'b0, fx_q});
    b_w      = ph_q[1] ? {1'b0, fy_q} : (ONE_S - {1'b0, fy_q});
    wgt_full = (2 * FRAC_BITS + 2)'(a_w) * (2 * FRAC_BITS + 2)'(b_w);
    wgt_d    = wgt_full[WGT_W-1:0];
    raddr    = base_q + ({IDX_W{ph_q[1]}} & IDX_W'(w_eff)) + IDX_W'(ph_q[0]);
    rd_en    = (state_q == S_RUN) && !ph_q[2];
  end

  // multiply the returned entry into a product register, then accumulate it in the cycle after
  logic prod_phase, acc_phase;
  assign prod_phase = (state_q == S_RUN) && (ph_q >= 3'd1) && (ph_q <= 3'd4);
  assign acc_phase  = (state_q == S_RUN) && (ph_q >= 3'd2);

  always_comb begin
    prod_d[0] = $signed(rdata_q.x) * $signed({1'b0, wgt_q});
    prod_d[1] = $signed(rdata_q.y) * $signed({1'b0, wgt_q});
    prod_d[2] = $signed(rdata_q.z) * $signed({1'b0, wgt_q});
    for (int i = 0; i < 3; i++) begin
      if ((state_q == S_RUN) && (ph_q == 3'd0)) begin
        acc_d[i] = '0;
      end else if (acc_phase) begin
        acc_d[i] = acc_q[i] + prod_q[i];
      end else begin
        acc_d[i] = acc_q[i];
      end
      rnd[i] = acc_q[i] + $signed(RND);
    end
    if ((state_q == S_RUN) && (ph_q == 3'd0)) begin
      all_vld_d = 1'b1;
    end else if (prod_phase) begin
      all_vld_d = all_vld_q && rdata_q.valid;
    end else begin
      all_vld_d = all_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_ADDR) begin
      base_q <= base_d;
      fx_q   <= col_q[FRAC_BITS-1:0];
      fy_q   <= row_q[FRAC_BITS-1:0];
      inb_q  <= inb_d;
    end
    wgt_q     <= wgt_d;
    all_vld_q <= all_vld_d;
    for (int i = 0; i < 3; i++) begin
      if (prod_phase) begin
        prod_q[i] <= prod_d[i];
      end
      acc_q[i] <= acc_d[i];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (opcode_i == OP_QUERY)) begin
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        ph_d    = 3'd0;
        state_d = inb_d ? S_RUN : S_DONE;
      end
      S_RUN: begin
        ph_d = ph_q + 3'd1;
        if (ph_q == 3'd5) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= 3'd0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      done_q  <= (state_q == S_DONE);
    end
  end

  // result registers: rounded blend, zero when invalid
  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE) begin
      res_vld_q <= inb_q && all_vld_q;
      for (int i = 0; i < 3; i++) begin
        res_q[i] <= (inb_q && all_vld_q) ? rnd[i][2*FRAC_BITS+COORD_W-1:2*FRAC_BITS]
                                          : '0;
      end
    end
  end

  assign done_o         = done_q;
  assign result_x_o     = $signed(res_q[0]);
  assign result_y_o     = $signed(res_q[1]);
  assign result_z_o     = $signed(res_q[2]);
  assign result_valid_o = res_vld_q;

endmodule

`default_nettype wire

// ===== src/pmbs_checker.sv =====
// Port-level checks for the point map bilinear sampler, bound to the top level.
// Depends on pmbs_pkg and point_map_bilinear_sampler.
`default_nettype none

module pmbs_checker
  import pmbs_pkg::*;
(
  input wire                       clk_i,
  input wire                       rst_ni,
  input wire                       start,
  input wire                       busy,
  input wire                       opcode_i,
  input wire                       done_o,
  input wire                       result_valid_o,
  input wire signed [COORD_W-1:0]  result_x_o,
  input wire signed [COORD_W-1:0]  result_y_o,
  input wire signed [COORD_W-1:0]  result_z_o
);

  // a result only shows once the query has left the sequencer
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // an invalid result carries zeros
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_valid_o) |->
      (result_x_o == 0 && result_y_o == 0 && result_z_o == 0))
    else $error("invalid result with nonzero payload");

  // a load transaction neither blocks nor yields a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == OP_LOAD) |=> (!busy && !done_o))
    else $error("load transaction caused busy or a result");

  // a query transaction holds off the next command
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == OP_QUERY) |=> (busy && !done_o))
    else $error("query transaction did not raise busy");

endmodule

bind point_map_bilinear_sampler pmbs_checker u_pmbs_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for point_map_bilinear_sampler: loads, bilinear queries, map sizes.
// Predicts every query result from a local copy of the point map; depends on pmbs_pkg and the RTL.
`default_nettype none

module tb;
  import pmbs_pkg::*;

  localparam int unsigned FRAC_MAX      = (1 << FRAC_BITS) - 1;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned STALL_LIMIT   = 400;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

  // clock, reset and block ports
  logic                       clk_i  = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start  = 1'b0;
  logic                       busy;
  logic                       opcode_i      = OP_LOAD;
  logic         [IDX_W-1:0]   point_index_i = '0;
  logic signed  [COORD_W-1:0] point_x_i     = '0;
  logic signed  [COORD_W-1:0] point_y_i     = '0;
  logic signed  [COORD_W-1:0] point_z_i     = '0;
  logic                       point_valid_i = 1'b0;
  logic signed  [POS_W-1:0]   query_col_i   = '0;
  logic signed  [POS_W-1:0]   query_row_i   = '0;
  logic                       done_o;
  logic signed  [COORD_W-1:0] result_x_o;
  logic signed  [COORD_W-1:0] result_y_o;
  logic signed  [COORD_W-1:0] result_z_o;
  logic                       result_valid_o;
  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic         [PADDR_W-1:0] paddr   = '0;
  logic         [PDATA_W-1:0] pwdata  = '0;
  logic         [PDATA_W-1:0] prdata;
  logic                       pready;

  // local copy of the map and the size registers
  entry_t         map_model   [STORE_DEPTH];
  bit             map_written [STORE_DEPTH];
  logic [DIM_W-1:0] cfg_width  = DIM_RESET;
  logic [DIM_W-1:0] cfg_height = DIM_RESET;

  // blends still owed by the block, oldest first
  entry_t      expected_samples [$];
  entry_t      due_sample;
  int          error_count  = 0;
  int unsigned items_sent   = 0;
  int unsigned idle_pct     = 0;
  int unsigned stall_cycles = 0;

  point_map_bilinear_sampler DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .point_index_i  (point_index_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .point_z_i      (point_z_i),
    .point_valid_i  (point_valid_i),
    .query_col_i    (query_col_i),
    .query_row_i    (query_row_i),
    .done_o         (done_o),
    .result_x_o     (result_x_o),
    .result_y_o     (result_y_o),
    .result_z_o     (result_z_o),
    .result_valid_o (result_valid_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- prediction

  // map size in use, saturated at the store limits
  function automatic int unsigned map_cols();
    return (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
  endfunction

  function automatic int unsigned map_rows();
    return (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
  endfunction

  // top-left entry of the cell under a position; 0 if the cell is off the map
  function automatic bit locate_cell(input logic signed [POS_W-1:0] col,
                                     input logic signed [POS_W-1:0] row,
                                     output int unsigned base);
    int unsigned c0;
    int unsigned r0;
    base = 0;
    if (col[POS_W-1] || row[POS_W-1]) return 1'b0;
    c0 = col[POS_W-1:FRAC_BITS];
    r0 = row[POS_W-1:FRAC_BITS];
    if (c0 + 1 >= map_cols() || r0 + 1 >= map_rows()) return 1'b0;
    base = r0 * map_cols() + c0;
    return 1'b1;
  endfunction

  // weighted sum of four corners, rounded to nearest with ties upward
  function automatic logic signed [COORD_W-1:0] blend_axis(
      input logic signed [COORD_W-1:0] a, b, c, d,
      input longint wa, wb, wc, wd);
    longint acc;
    acc = longint'(a) * wa + longint'(b) * wb + longint'(c) * wc + longint'(d) * wd;
    acc = (acc + (longint'(1) << (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
    return acc[COORD_W-1:0];
  endfunction

  function automatic entry_t predict_sample(input logic signed [POS_W-1:0] col,
                                            input logic signed [POS_W-1:0] row);
    entry_t      sample;
    entry_t      p0, p1, p2, p3;
    int unsigned base;
    int unsigned w;
    longint      s, fx, fy, w0, w1, w2, w3;
    sample = '0;
    if (!locate_cell(col, row, base)) return sample;
    w  = map_cols();
    p0 = map_model[base];
    p1 = map_model[base + 1];
    p2 = map_model[base + w];
    p3 = map_model[base + w + 1];
    if (!(p0.valid && p1.valid && p2.valid && p3.valid)) return sample;
    s  = longint'(1) << FRAC_BITS;
    fx = longint'(col[FRAC_BITS-1:0]);
    fy = longint'(row[FRAC_BITS-1:0]);
    w0 = (s - fx) * (s - fy);
    w1 = fx * (s - fy);
    w2 = (s - fx) * fy;
    w3 = fx * fy;
    sample.valid = 1'b1;
    sample.x = blend_axis(p0.x, p1.x, p2.x, p3.x, w0, w1, w2, w3);
    sample.y = blend_axis(p0.y, p1.y, p2.y, p3.y, w0, w1, w2, w3);
    sample.z = blend_axis(p0.z, p1.z, p2.z, p3.z, w0, w1, w2, w3);
    return sample;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input longint want, input longint got);
    error_count++;
    if (error_count <= 10)
      $display("mismatch in %s: expected %0d, got %0d", what, want, got);
  endtask

  // every strobed result is compared with the oldest pending blend
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("result without a pending query", 0, 1);
      end else begin
        due_sample = expected_samples.pop_front();
        if (result_valid_o !== due_sample.valid)
          report_mismatch("result_valid", due_sample.valid, result_valid_o);
        if (result_x_o !== due_sample.x) report_mismatch("result_x", due_sample.x, result_x_o);
        if (result_y_o !== due_sample.y) report_mismatch("result_y", due_sample.y, result_y_o);
        if (result_z_o !== due_sample.z) report_mismatch("result_z", due_sample.z, result_z_o);
      end
    end
  end

  // watchdog: cycles in a row with no transaction on any port
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (psel && penable && pready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("point_map_bilinear_sampler verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return COORD_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      default: return COORD_W'($urandom());
    endcase
  endfunction

  function automatic logic signed [POS_W-1:0] rand_pos();
    return POS_W'($urandom());
  endfunction

  function automatic logic signed [POS_W-1:0] make_pos(input int unsigned cell_num,
                                                       input int unsigned frac);
    return POS_W'((cell_num << FRAC_BITS) | frac);
  endfunction

  // random gap after a transaction
  task automatic maybe_idle();
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  // present one command and wait for it to be taken
  task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                           input logic signed [COORD_W-1:0] px, py, pz, input logic pv,
                           input logic signed [POS_W-1:0] qc, qr);
    entry_t pt;
    opcode_i      <= op;
    point_index_i <= idx;
    point_x_i     <= px;
    point_y_i     <= py;
    point_z_i     <= pz;
    point_valid_i <= pv;
    query_col_i   <= qc;
    query_row_i   <= qr;
    start         <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    if (op == OP_LOAD) begin
      pt.x = px;
      pt.y = py;
      pt.z = pz;
      pt.valid = pv;
      map_model[idx]   = pt;
      map_written[idx] = 1'b1;
    end else begin
      expected_samples.push_back(predict_sample(qc, qr));
    end
    items_sent++;
    maybe_idle();
  endtask

  task automatic load_point(input int unsigned idx, input logic signed [COORD_W-1:0] px, py, pz,
                            input logic pv);
    send_item(OP_LOAD, IDX_W'(idx), px, py, pz, pv, rand_pos(), rand_pos());
  endtask

  // load the four corners of a cell, or only those never written
  task automatic fill_cell(input int unsigned base, input bit only_missing);
    int unsigned corner [4];
    corner = '{base, base + 1, base + map_cols(), base + map_cols() + 1};
    foreach (corner[k])
      if (!only_missing || !map_written[corner[k]])
        load_point(corner[k], rand_coord(), rand_coord(), rand_coord(),
                   $urandom_range(0, 9) != 0);
  endtask

  // a query never reads an entry that was not loaded first
  task automatic query_point(input logic signed [POS_W-1:0] col,
                             input logic signed [POS_W-1:0] row);
    int unsigned base;
    if (locate_cell(col, row, base)) fill_cell(base, 1'b1);
    send_item(OP_QUERY, IDX_W'($urandom()), rand_coord(), rand_coord(), rand_coord(),
              1'(($urandom())), col, row);
  endtask

  // wait until every result is in and the block has gone quiet
  task automatic settle_block();
    start <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one APB transaction: setup cycle, then access until pready
  task automatic apb_transfer(input logic wr, input logic sel, input logic [PDATA_W-1:0] data,
                              output logic [PDATA_W-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (wr) begin
      if (sel == REG_WIDTH) cfg_width = data[DIM_W-1:0];
      else cfg_height = data[DIM_W-1:0];
    end
  endtask

  task automatic check_dimension(input logic sel, input logic [DIM_W-1:0] want);
    logic [PDATA_W-1:0] rdata;
    apb_transfer(1'b0, sel, '0, rdata);
    if (rdata[DIM_W-1:0] !== want)
      report_mismatch(sel == REG_WIDTH ? "map_width readback" : "map_height readback",
                      want, rdata[DIM_W-1:0]);
  endtask

  // write a size register while idle; upper data bits are noise
  task automatic set_dimension(input logic sel, input logic [DIM_W-1:0] dim);
    logic [PDATA_W-1:0] rdata;
    settle_block();
    apb_transfer(1'b1, sel, {(PDATA_W - DIM_W)'($urandom()), dim}, rdata);
    check_dimension(sel, dim);
  endtask

  // cell index near or past the map edge
  function automatic int unsigned edge_cell(input int unsigned n);
    case ($urandom_range(0, 3))
      0:       return (n >= 2) ? n - 2 : 0;
      1:       return (n >= 1) ? n - 1 : 0;
      2:       return n;
      default: return $urandom_range(n, (1 << (POS_W - FRAC_BITS)) - 1);
    endcase
  endfunction

  // mostly load-then-query on one cell, with stray loads and off-map queries
  task automatic run_traffic(input logic [DIM_W-1:0] width, input logic [DIM_W-1:0] height,
                             input int unsigned n_items, input int unsigned idle_level);
    int unsigned target;
    int unsigned w, h, c0, r0, pick;
    set_dimension(REG_WIDTH, width);
    set_dimension(REG_HEIGHT, height);
    idle_pct = idle_level;
    w = map_cols();
    h = map_rows();
    target = items_sent + n_items;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55 && w >= 2 && h >= 2) begin
        c0 = $urandom_range(0, w - 2);
        r0 = $urandom_range(0, h - 2);
        if ($urandom_range(0, 2) == 0) fill_cell(r0 * w + c0, 1'b0);
        repeat ($urandom_range(1, 3))
          query_point(make_pos(c0, $urandom_range(0, FRAC_MAX)),
                      make_pos(r0, $urandom_range(0, FRAC_MAX)));
      end else if (pick < 70) begin
        load_point($urandom_range(0, STORE_DEPTH - 1), rand_coord(), rand_coord(),
                   rand_coord(), 1'($urandom()));
      end else if (pick < 85) begin
        query_point(rand_pos(), rand_pos());
      end else begin
        query_point(make_pos(edge_cell(w), $urandom_range(0, FRAC_MAX)),
                    make_pos(edge_cell(h), $urandom_range(0, FRAC_MAX)));
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  // reset sizes read back; far corner cell and both edges of the full map
  task automatic test_reset_defaults();
    check_dimension(REG_WIDTH, DIM_RESET);
    check_dimension(REG_HEIGHT, DIM_RESET);
    idle_pct = 0;
    query_point(make_pos(MAX_WIDTH - 2, FRAC_MAX), make_pos(MAX_HEIGHT - 2, 1));
    query_point(make_pos(MAX_WIDTH - 1, 0), make_pos(0, 0));
    query_point(make_pos(0, 0), make_pos(MAX_HEIGHT - 1, 5));
  endtask

  // coordinate extremes, rounding ties, negative and edge positions, invalid neighbor
  task automatic test_field_extremes();
    set_dimension(REG_WIDTH, 3);
    set_dimension(REG_HEIGHT, 3);
    idle_pct = 20;
    load_point(0, COORD_MAX, COORD_MAX, COORD_MIN, 1'b1);
    load_point(1, COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
    load_point(2, -1, 0, 1, 1'b1);
    load_point(3, COORD_MAX, COORD_MAX, COORD_MIN, 1'b1);
    load_point(4, COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
    load_point(5, rand_coord(), rand_coord(), rand_coord(), 1'b1);
    query_point(make_pos(0, 0), make_pos(0, 0));
    query_point(make_pos(0, FRAC_MAX), make_pos(0, FRAC_MAX));
    // halfway between the two extremes: a tie
    query_point(make_pos(0, (FRAC_MAX + 1) / 2), make_pos(0, 0));
    query_point(make_pos(1, 64), make_pos(0, 192));
    // last column, last row
    query_point(make_pos(2, 0), make_pos(0, 0));
    query_point(make_pos(0, 0), make_pos(2, 17));
    // negative positions and the largest positive one
    query_point('1, make_pos(0, 0));
    query_point(make_pos(0, 0), {1'b1, {(POS_W - 1){1'b0}}});
    query_point({1'b0, {(POS_W - 1){1'b1}}}, {1'b0, {(POS_W - 1){1'b1}}});
    // one missing neighbor spoils the cell
    load_point(5, rand_coord(), rand_coord(), rand_coord(), 1'b0);
    query_point(make_pos(1, 10), make_pos(0, 10));
    load_point(STORE_DEPTH - 1, rand_coord(), rand_coord(), rand_coord(), 1'b1);
  endtask

  task automatic test_smallest_map();
    run_traffic(2, 2, 200, 30);
  endtask

  // sizes above the store limit saturate
  task automatic test_oversized_map();
    run_traffic(255, 200, 300, 25);
  endtask

  // no cell exists when either size is below two
  task automatic test_degenerate_maps();
    run_traffic(0, 0, 30, 40);
    run_traffic(1, 128, 30, 20);
    run_traffic(128, 1, 30, 20);
  endtask

  task automatic test_mixed_maps();
    run_traffic(7, 13, 300, 50);
    run_traffic(DIM_W'($urandom_range(2, MAX_WIDTH)), DIM_W'($urandom_range(2, MAX_HEIGHT)),
                300, 10);
    run_traffic(128, 128, 300, 30);
  endtask

  // closing stretch with commands back to back
  task automatic test_back_to_back();
    run_traffic(5, 9, 300, 0);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_field_extremes();
    test_smallest_map();
    test_oversized_map();
    test_degenerate_maps();
    test_mixed_maps();
    test_back_to_back();
    settle_block();
    if (error_count == 0 && expected_samples.size() == 0) begin
      $display("point_map_bilinear_sampler verification clean");
    end else begin
      $display("point_map_bilinear_sampler verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
